>>> sv/virtual_spring_force_to_length_loop_assert.svh
// Assertion macros for the virtual spring loop.
// Used by the top level only; expects clk and rst in scope.
`ifndef VIRTUAL_SPRING_FORCE_TO_LENGTH_LOOP_ASSERT_SVH
`define VIRTUAL_SPRING_FORCE_TO_LENGTH_LOOP_ASSERT_SVH
// same-cycle implication
`define VSFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define VSFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> sv/vsfl_pkg.sv
// Shared constants and codes for the virtual spring loop.
// No dependencies.
package vsfl_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [15:0] ZERO_CODE = 16'h8000;
  localparam logic [15:0] RAMP_STEP = 16'h0010;

  localparam logic [1:0] KIND_CAL  = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_RAMP = 2'd2;

  localparam logic [2:0] REG_ALPHA  = 3'd0;
  localparam logic [2:0] REG_WINDOW = 3'd1;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_SLEW   = 3'd4;

  localparam int MUL_B_W = 18;
  localparam int DIVISOR_W = 17;
endpackage

>>> sv/vsfl_mul.sv
// Registered signed multiplier shared by the loop sequencer.
// Depends on vsfl_pkg.
module vsfl_mul #(
  parameter int FRAC_BITS = vsfl_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic signed [FRAC_BITS+16:0] a,
  input  logic signed [vsfl_pkg::MUL_B_W-1:0] b,
  output logic signed [FRAC_BITS+16+vsfl_pkg::MUL_B_W:0] p
);
  import vsfl_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

>>> sv/vsfl_div.sv
// Bit-serial signed divider, quotient rounded toward minus infinity.
// Depends on vsfl_pkg; one quotient bit per cycle.
module vsfl_div #(
  parameter int FRAC_BITS = vsfl_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [FRAC_BITS+33:0] dividend,
  input  logic [vsfl_pkg::DIVISOR_W-1:0] divisor,
  output logic busy,
  output logic done,
  output logic signed [FRAC_BITS+33:0] quotient
);
  import vsfl_pkg::*;

  localparam int DW = FRAC_BITS + 34;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] quo;
  logic [DIVISOR_W:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [CW-1:0] cnt;
  logic neg;
  logic [DIVISOR_W:0] rem_sh;
  logic fits;

  assign rem_sh = {rem[DIVISOR_W-1:0], quo[DW-1]};
  assign fits = rem_sh >= {1'b0, dsr};
  assign quotient = neg ? ~quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        neg <= dividend[DW-1];
        quo <= dividend[DW-1] ? ~dividend : dividend;
        rem <= '0;
        dsr <= divisor;
        cnt <= CW'(DW - 1);
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/virtual_spring_force_to_length_loop.sv
// Channel  Dir  Payload
// s_axis   in   tuser: kind[1:0]; tdata: adc_code[15:0]
// m_axis   out  tuser: calibrated, ramp_done; tdata: dac_code, smoothed_level
// cfg      in   cfg_index selects register, cfg_data is the value
// Run samples pass the low-pass, window, divider, spring multiply and slew steps; calibration
// samples take an offset step instead, the last of a round waiting on a second divider pass;
// ramp ticks take the ramp step, other kinds go to output. s_axis_tready is high only while idle.
// A result not yet taken holds the sequencer at the output step until m_axis_tready.
// Reset is synchronous and restores the power-up state.
// Top level of the virtual spring loop; depends on vsfl_pkg, vsfl_mul,
// vsfl_div and the assertion header.
`include "virtual_spring_force_to_length_loop_assert.svh"
module virtual_spring_force_to_length_loop #(
  parameter int FRAC_BITS = vsfl_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // adc_code[15:0]
  input  logic [1:0] s_axis_tuser,   // kind[1:0]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,  // dac_code[15:0], smoothed_level[31:16]
  output logic [1:0] m_axis_tuser,   // calibrated[0], ramp_done[1]
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import vsfl_pkg::*;

  localparam int LW = FRAC_BITS + 16;
  localparam int AW = FRAC_BITS + 17;
  localparam int MW = FRAC_BITS + 17 + MUL_B_W;
  localparam int DW = FRAC_BITS + 34;
  localparam int SW = FRAC_BITS + 33;
  localparam int SHW = MW - FRAC_BITS - 8;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LP_MUL, ST_LP_ACC, ST_WIN_MUL, ST_WIN_DIV, ST_WIN_WAIT,
    ST_CAL, ST_CAL_WAIT, ST_RUN_MUL, ST_RUN_FIN, ST_RAMP, ST_OUT
  } state_t;

  state_t state;
  logic [15:0] filter_alpha, passive_count, slew_limit;
  logic [7:0] window_size;
  logic signed [15:0] spring_gain;
  logic [1:0] kind;
  logic signed [15:0] adc_code;
  logic signed [LW-1:0] lowpass_level, window_level, passive_level;
  logic signed [SW-1:0] offset_sum;
  logic [15:0] calib_seen, drive_code;
  logic is_calibrated, ramp_done;

  logic signed [AW-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MW-1:0] prod;
  logic div_start, div_busy, div_done;
  logic signed [DW-1:0] div_num, quotient;
  logic [DIVISOR_W-1:0] div_den;

  logic [7:0] win_n;
  logic signed [SW-1:0] sum_next;
  logic [15:0] seen_next;
  logic cal_fin;
  logic signed [SHW-1:0] spring;
  logic signed [SHW:0] cand;
  logic [16:0] cand_sat;
  logic [17:0] up_lim, cur_ext, lim_ext;
  logic [15:0] drive_run;

  vsfl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  vsfl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .busy(div_busy), .done(div_done), .quotient(quotient)
  );

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign win_n = (window_size == '0) ? 8'd1 : window_size;
  assign sum_next = offset_sum + SW'(window_level);
  assign seen_next = calib_seen + 16'd1;
  assign cal_fin = (seen_next == '0) || (seen_next >= passive_count);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LP_MUL: begin
        mul_a = AW'($signed({adc_code, FRAC_BITS'(0)})) - AW'(lowpass_level);
        mul_b = MUL_B_W'({1'b0, filter_alpha});
      end
      ST_WIN_MUL: begin
        mul_a = AW'(window_level);
        mul_b = MUL_B_W'({1'b0, win_n - 8'd1});
      end
      ST_RUN_MUL: begin
        mul_a = AW'(window_level) - AW'(passive_level);
        mul_b = MUL_B_W'(spring_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num = DW'(prod[DW-1:0]) + DW'(lowpass_level);
    div_den = DIVISOR_W'(win_n);
    if (state == ST_WIN_DIV) begin
      div_start = 1'b1;
    end else if (state == ST_CAL && cal_fin) begin
      div_start = 1'b1;
      div_num = DW'(sum_next);
      div_den = (seen_next == '0) ? DIVISOR_W'(65536) : DIVISOR_W'(seen_next);
    end
  end

  assign spring = prod[MW-1:FRAC_BITS+8];
  assign cand = (SHW+1)'(spring) + (SHW+1)'(32768);
  assign cand_sat = cand[SHW] ? 17'd0 :
                    (cand > (SHW+1)'(65535)) ? 17'd65535 : cand[16:0];
  assign cur_ext = {2'b0, drive_code};
  assign lim_ext = {2'b0, slew_limit};
  assign up_lim = cur_ext + lim_ext;
  always_comb begin
    if ({1'b0, cand_sat} > up_lim) begin
      drive_run = up_lim[15:0];
    end else if ({1'b0, cand_sat} + lim_ext < cur_ext) begin
      drive_run = drive_code - slew_limit;
    end else begin
      drive_run = cand_sat[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      filter_alpha <= 16'd7702;
      window_size <= 8'd38;
      passive_count <= 16'd1000;
      spring_gain <= -16'sd8561;
      slew_limit <= 16'd10000;
      lowpass_level <= '0;
      window_level <= '0;
      offset_sum <= '0;
      passive_level <= '0;
      calib_seen <= '0;
      is_calibrated <= 1'b0;
      drive_code <= ZERO_CODE;
      ramp_done <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ALPHA:  filter_alpha <= cfg_data;
          REG_WINDOW: window_size <= cfg_data[7:0];
          REG_COUNT:  passive_count <= cfg_data;
          REG_GAIN:   spring_gain <= cfg_data;
          REG_SLEW:   slew_limit <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= s_axis_tuser;
            adc_code <= s_axis_tdata;
            ramp_done <= 1'b0;
            case (s_axis_tuser)
              KIND_CAL, KIND_RUN: state <= ST_LP_MUL;
              KIND_RAMP: state <= ST_RAMP;
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_LP_MUL: state <= ST_LP_ACC;
        ST_LP_ACC: begin
          lowpass_level <= lowpass_level + LW'(prod >>> 16);
          state <= ST_WIN_MUL;
        end
        ST_WIN_MUL: state <= ST_WIN_DIV;
        ST_WIN_DIV: state <= ST_WIN_WAIT;
        ST_WIN_WAIT: begin
          if (div_done) begin
            window_level <= LW'(quotient);
            state <= (kind == KIND_CAL) ? ST_CAL : ST_RUN_MUL;
          end
        end
        ST_CAL: begin
          drive_code <= ZERO_CODE;
          if (cal_fin) begin
            state <= ST_CAL_WAIT;
          end else begin
            offset_sum <= sum_next;
            calib_seen <= seen_next;
            state <= ST_OUT;
          end
        end
        ST_CAL_WAIT: begin
          if (div_done) begin
            passive_level <= LW'(quotient);
            is_calibrated <= 1'b1;
            offset_sum <= '0;
            calib_seen <= '0;
            state <= ST_OUT;
          end
        end
        ST_RUN_MUL: state <= ST_RUN_FIN;
        ST_RUN_FIN: begin
          drive_code <= drive_run;
          state <= ST_OUT;
        end
        ST_RAMP: begin
          if (drive_code > ZERO_CODE + RAMP_STEP) begin
            drive_code <= drive_code - RAMP_STEP;
          end else if (drive_code < ZERO_CODE - RAMP_STEP) begin
            drive_code <= drive_code + RAMP_STEP;
          end else begin
            drive_code <= ZERO_CODE;
            ramp_done <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {window_level[FRAC_BITS+15:FRAC_BITS], drive_code};
            m_axis_tuser <= {ramp_done, is_calibrated};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `VSFL_ASSERT_NOW(a_ramp_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[15:0] == ZERO_CODE, "ramp done off zero code")
  `VSFL_ASSERT_NOW(a_cal_sticky, 1'b1, !$fell(is_calibrated), "calibrated flag dropped")
  `VSFL_ASSERT_NOW(a_div_idle, div_done, state == ST_WIN_WAIT || state == ST_CAL_WAIT, "divider result unclaimed")
  `VSFL_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
  `VSFL_ASSERT_NEXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")
endmodule

>>> tb/spring_loop_checker.sv
// Checker for the virtual spring loop: watches the sample, result and register channels,
// predicts each result word from its own copy of the filter state and compares field by field.
// Depends on vsfl_pkg.
`timescale 1ns / 1ps
module spring_loop_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // adc_code[15:0]
  input  logic [1:0] s_axis_tuser,   // kind[1:0]
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // dac_code[15:0], smoothed_level[31:16]
  input  logic [1:0] m_axis_tuser,   // calibrated[0], ramp_done[1]
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int errors,
  output int pending
);
  import vsfl_pkg::*;

  typedef struct packed {
    logic [15:0] dac;
    logic cal;
    logic done;
    logic [15:0] level;
  } spring_word_t;

  spring_word_t dac_expect_q[$];

  logic [15:0] alpha_reg;
  logic [7:0] window_reg;
  logic [15:0] count_reg;
  logic signed [15:0] gain_reg;
  logic [15:0] slew_reg;

  longint lowpass_lvl, window_lvl, offset_acc, passive_lvl;
  logic [15:0] cal_samples;
  logic is_cal;
  logic [15:0] drive;

  function automatic longint floor_div(longint v, longint n);
    if (v >= 0) return v / n;
    return -((-(v + 1)) / n) - 1;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void smooth_sample(longint x);
    longint n;
    n = (window_reg == 0) ? 1 : longint'(window_reg);
    lowpass_lvl += (((x <<< FRAC_BITS_DEF) - lowpass_lvl) * longint'(alpha_reg)) >>> 16;
    window_lvl = floor_div(window_lvl * (n - 1) + lowpass_lvl, n);
  endfunction

  function automatic spring_word_t spring_predict(logic [1:0] kind, logic signed [15:0] adc);
    spring_word_t w;
    longint cand, cur, lim, cnt;
    w.done = 1'b0;
    if (kind == KIND_CAL) begin
      smooth_sample(longint'(adc));
      drive = ZERO_CODE;
      offset_acc += window_lvl;
      cal_samples = cal_samples + 16'd1;
      if (cal_samples == 0 || cal_samples >= count_reg) begin
        cnt = (cal_samples == 0) ? 65536 : longint'(cal_samples);
        passive_lvl = floor_div(offset_acc, cnt);
        is_cal = 1'b1;
        offset_acc = 0;
        cal_samples = 0;
      end
    end else if (kind == KIND_RUN) begin
      smooth_sample(longint'(adc));
      cur = longint'(drive);
      lim = longint'(slew_reg);
      cand = 32768 + (((window_lvl - passive_lvl) * longint'(gain_reg)) >>> (FRAC_BITS_DEF + 8));
      if (cand < 0) cand = 0;
      if (cand > 65535) cand = 65535;
      if (cand > cur + lim) cur = cur + lim;
      else if (cand < cur - lim) cur = cur - lim;
      else cur = cand;
      drive = cur[15:0];
    end else if (kind == KIND_RAMP) begin
      if (drive > ZERO_CODE + RAMP_STEP) drive = drive - RAMP_STEP;
      else if (drive < ZERO_CODE - RAMP_STEP) drive = drive + RAMP_STEP;
      else begin
        drive = ZERO_CODE;
        w.done = 1'b1;
      end
    end
    w.dac = drive;
    w.cal = is_cal;
    w.level = 16'(window_lvl >>> FRAC_BITS_DEF);
    return w;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    spring_word_t want;
    if (rst) begin
      alpha_reg = 16'd7702;
      window_reg = 8'd38;
      count_reg = 16'd1000;
      gain_reg = -16'sd8561;
      slew_reg = 16'd10000;
      lowpass_lvl = 0;
      window_lvl = 0;
      offset_acc = 0;
      passive_lvl = 0;
      cal_samples = 0;
      is_cal = 1'b0;
      drive = ZERO_CODE;
      dac_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHA: alpha_reg = cfg_data;
          REG_WINDOW: window_reg = cfg_data[7:0];
          REG_COUNT: count_reg = cfg_data;
          REG_GAIN: gain_reg = cfg_data;
          REG_SLEW: slew_reg = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (dac_expect_q.size() == 0) begin
          report("unexpected result word", 1, 0);
        end else begin
          want = dac_expect_q.pop_front();
          if (m_axis_tdata[15:0] !== want.dac) report("dac_code", m_axis_tdata[15:0], want.dac);
          if (m_axis_tuser[0] !== want.cal) report("calibrated", m_axis_tuser[0], want.cal);
          if (m_axis_tuser[1] !== want.done) report("ramp_done", m_axis_tuser[1], want.done);
          if (m_axis_tdata[31:16] !== want.level)
            report("smoothed_level", $signed(m_axis_tdata[31:16]), $signed(want.level));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        dac_expect_q.push_back(spring_predict(s_axis_tuser, s_axis_tdata));
    end
    pending = dac_expect_q.size();
  end
endmodule

>>> tb/testbench.sv
// Top of the virtual spring loop testbench: clock, reset, sample and register stimulus,
// result-side back-pressure and the verdict. Depends on vsfl_pkg, spring_loop_checker and the top level.
`timescale 1ns / 1ps
module testbench;
  import vsfl_pkg::*;

  localparam int SETTLE = 300;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // adc_code[15:0]
  logic [1:0] s_axis_tuser = '0;   // kind[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // dac_code[15:0], smoothed_level[31:16]
  logic [1:0] m_axis_tuser;        // calibrated[0], ramp_done[1]
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int errors, pending;

  bit idle_on = 1'b1;
  int hold_len = 0;
  int stall = 0;
  int quiet = 0;
  logic took = 1'b0;
  int cal_len = 1000;
  logic signed [15:0] level;

  always #6 clk = ~clk;

  virtual_spring_force_to_length_loop u_dut (.*);

  spring_loop_checker u_chk (.*);

  always @(posedge clk) took <= m_axis_tvalid & m_axis_tready;

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      if (took) stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall = stall - 1;
      end else m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || took || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] kind, logic [15:0] adc);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser <= kind;
    s_axis_tdata <= adc;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic setup(logic [15:0] a, logic [15:0] w, logic [15:0] c, logic [15:0] g,
                       logic [15:0] s);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(REG_ALPHA, a);
    write_reg(REG_WINDOW, w);
    write_reg(REG_COUNT, c);
    write_reg(REG_GAIN, g);
    write_reg(REG_SLEW, s);
    cfg_valid <= 1'b0;
    cal_len = (c == 0) ? 1 : int'(c);
  endtask

  function automatic logic [15:0] draw_adc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h8000;
    if (r < 10) return 16'h7fff;
    if (r < 25) return 16'($urandom);
    return 16'(level + $signed($urandom_range(0, 400)) - 200);
  endfunction

  task automatic random_words(int total);
    int n, k;
    n = 0;
    while (n < total) begin
      level = 16'($urandom);
      if ($urandom_range(0, 99) < 10) begin
        send_word(2'($urandom_range(0, 3)), 16'($urandom));
        n++;
      end else begin
        k = (cal_len > 60) ? 60 : cal_len;
        if ($urandom_range(0, 3) != 0) k = cal_len;
        if ($urandom_range(0, 9) == 0) k = $urandom_range(1, k);
        repeat (k) send_word(KIND_CAL, draw_adc());
        n += k;
        k = $urandom_range(3, 30);
        repeat (k) send_word(KIND_RUN, draw_adc());
        n += k;
        k = $urandom_range(1, 40);
        repeat (k) send_word(KIND_RAMP, 16'($urandom));
        n += k;
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    send_word(KIND_RUN, 16'd100);
    send_word(KIND_RAMP, 16'hffff);
    send_word(KIND_CAL, 16'd0);

    setup(16'hffff, 16'd1, 16'd3, 16'h7fff, 16'hffff);
    send_word(KIND_CAL, 16'h7fff);
    send_word(KIND_CAL, 16'h8000);
    send_word(KIND_RUN, 16'h7fff);
    send_word(KIND_RUN, 16'h8000);
    send_word(KIND_RAMP, 16'h0000);
    send_word(2'd3, 16'h5a5a);
    send_word(KIND_CAL, 16'h0000);
    send_word(KIND_CAL, 16'h0001);
    send_word(KIND_CAL, 16'hffff);
    send_word(KIND_RAMP, 16'h0000);
    send_word(KIND_RUN, 16'h7fff);
    send_word(KIND_RAMP, 16'h0000);

    setup(16'h0000, 16'h00ff, 16'd0, 16'h8000, 16'd0);
    send_word(KIND_CAL, 16'h7fff);
    send_word(KIND_RUN, 16'h8000);
    send_word(KIND_RUN, 16'h7fff);
    send_word(KIND_RAMP, 16'h0000);
    random_words(100);

    setup(16'd7702, 16'd38, 16'd10, 16'hde8f, 16'd10000);
    random_words(300);

    setup(16'hffff, 16'd0, 16'd50, 16'h7fff, 16'hffff);
    idle_on = 1'b0;
    hold_len = 300;
    random_words(200);
    idle_on = 1'b1;

    setup(16'd1, 16'd1, 16'd1, 16'd256, 16'd16);
    random_words(150);

    setup(16'd30000, 16'd8, 16'd20, 16'hde8f, 16'd500);
    random_words(300);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
